@@ rtl/bmh_pkg.sv @@
`default_nettype none
package bmh_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_CHK,
    S_UP_CMP,
    S_EXT_LOAD,
    S_DN_CHK,
    S_DN_CMP,
    S_FINAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic ins_push;
    logic set_full;
    logic set_empty;
    logic rd_ends;
    logic ext_load;
    logic rd_parent;
    logic move_up;
    logic rd_children;
    logic move_down;
    logic write_final;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op_extract;
    logic full;
    logic empty;
    logic at_root;
    logic no_child;
    logic parent_less;
    logic child_more;
  } stat_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
    logic [KEY_W-1:0] top_key;
    logic [KEY_W-1:0] extracted_key;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/bmh_ctrl.sv @@
`default_nettype none
module bmh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_free,
  input  wire bmh_pkg::stat_t st,
  output bmh_pkg::cmd_t      cmd
);
  import bmh_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!st.op_extract) begin
          if (st.full) begin
            cmd.set_full = 1'b1;
            state_next   = S_EMIT;
          end else begin
            cmd.ins_push = 1'b1;
            state_next   = S_UP_CHK;
          end
        end else begin
          if (st.empty) begin
            cmd.set_empty = 1'b1;
            state_next    = S_EMIT;
          end else begin
            cmd.rd_ends = 1'b1;
            state_next  = S_EXT_LOAD;
          end
        end
      end
      S_UP_CHK: begin
        if (st.at_root) begin
          state_next = S_FINAL;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.parent_less) begin
          cmd.move_up = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_EXT_LOAD: begin
        cmd.ext_load = 1'b1;
        state_next   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (st.no_child) begin
          state_next = S_FINAL;
        end else begin
          cmd.rd_children = 1'b1;
          state_next      = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (st.child_more) begin
          cmd.move_down = 1'b1;
          state_next    = S_DN_CHK;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.write_final = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/bmh_dp.sv @@
`default_nettype none
module bmh_dp #(
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [bmh_pkg::CNT_W-1:0] cfg_limit,
  input  wire logic                      op_in,
  input  wire logic [bmh_pkg::KEY_W-1:0] key_in,
  input  wire bmh_pkg::cmd_t             cmd,
  output bmh_pkg::stat_t                 st,
  output bmh_pkg::result_t               res
);
  import bmh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CNT_W) ? CW : CNT_W;
  localparam int XW = AW + 2;

  logic [KEY_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]        limit;
  logic [CW-1:0]           count;
  logic [AW-1:0]           pos;
  logic                    op;
  logic signed [KEY_W-1:0] key;
  logic [KEY_W-1:0]        extracted;
  logic [KEY_W-1:0]        top;
  logic [1:0]              status;
  logic signed [KEY_W-1:0] rd_a;
  logic signed [KEY_W-1:0] rd_b;

  logic [LW-1:0]    cnt_ext;
  logic [LW-1:0]    lim_ext;
  logic [LW-1:0]    eff_limit;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    pos_m1;
  logic [AW-1:0]    parent;
  logic [XW-1:0]    left;
  logic [XW-1:0]    right;
  logic [XW-1:0]    cnt_x;
  logic             right_ok;
  logic             pick_right;
  logic [AW-1:0]    pick_idx;
  logic signed [KEY_W-1:0] pick_val;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic             ren;
  logic             we;
  logic [KEY_W-1:0] wdata;

  assign cnt_ext   = LW'(count);
  assign lim_ext   = LW'(limit);
  assign eff_limit = (lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : lim_ext;
  assign cnt_m1    = count - 1'b1;
  assign pos_m1    = pos - 1'b1;
  assign parent    = pos_m1 >> 1;
  assign left      = {(XW-1)'(pos), 1'b1};
  assign right     = left + 1'b1;
  assign cnt_x     = XW'(count);
  assign right_ok  = right < cnt_x;

  // ties go to the left child
  assign pick_right = right_ok && (rd_a < rd_b);
  assign pick_idx   = pick_right ? right[AW-1:0] : left[AW-1:0];
  assign pick_val   = pick_right ? rd_b : rd_a;

  always_comb begin
    st.op_extract  = op;
    st.full        = cnt_ext >= eff_limit;
    st.empty       = count == '0;
    st.at_root     = pos == '0;
    st.no_child    = left >= cnt_x;
    st.parent_less = rd_a < key;
    st.child_more  = key < pick_val;
  end

  always_comb begin
    addr_a = parent;
    addr_b = right_ok ? right[AW-1:0] : left[AW-1:0];
    ren    = cmd.rd_ends | cmd.rd_parent | cmd.rd_children;
    if (cmd.rd_ends) begin
      addr_a = '0;
      addr_b = cnt_m1[AW-1:0];
    end else if (cmd.rd_children) begin
      addr_a = left[AW-1:0];
    end
  end

  always_comb begin
    we    = cmd.move_up | cmd.move_down | cmd.write_final;
    wdata = key;
    if (cmd.move_up) begin
      wdata = rd_a;
    end else if (cmd.move_down) begin
      wdata = pick_val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= wdata;
    end
    if (ren) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // root copy for the top key output
  always_ff @(posedge clk) begin
    if (we && pos == '0) begin
      top <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      count <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_limit;
      end
      if (cmd.ins_push) begin
        count <= count + 1'b1;
      end else if (cmd.ext_load) begin
        count <= cnt_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op        <= op_in;
      key       <= key_in;
      extracted <= '0;
      status    <= ST_OK;
    end
    if (cmd.set_full) begin
      status <= ST_FULL;
    end
    if (cmd.set_empty) begin
      status <= ST_EMPTY;
    end
    if (cmd.ins_push) begin
      pos <= count[AW-1:0];
    end
    if (cmd.ext_load) begin
      extracted <= rd_a;
      key       <= rd_b;
      pos       <= '0;
    end
    if (cmd.move_up) begin
      pos <= parent;
    end
    if (cmd.move_down) begin
      pos <= pick_idx;
    end
  end

  always_comb begin
    res.extracted_key = extracted;
    res.top_key       = (count == '0) ? '0 : top;
    res.entry_count   = cnt_ext[CNT_W-1:0];
    res.status        = status;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= LW'(DEPTH))
    else $error("entry count above depth");

  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    cmd.move_up |-> pos != '0)
    else $error("sift up past the root");

  a_ext_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.ext_load |=> count == $past(cnt_m1))
    else $error("extract did not drop the count");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_push |-> cnt_ext < eff_limit)
    else $error("insert into a full heap");
`endif

endmodule
`default_nettype wire

@@ rtl/binary_max_heap.sv @@
`default_nettype none
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tdata: key_in; tuser: op
// m_*       out  m_tvalid / m_tready       tdata: extracted, top, count; tuser: status
// cfg_*     in   cfg_valid / cfg_ready     capacity_limit
//
// One word at a time: an insert starts at the end and climbs while its parent is
// smaller; an extract moves the last key to the root and sinks it while a child
// is larger.
// Each level costs one registered read of the key memory and one compare.
// The result sits in an output register; the next word is taken while it waits.
// rst is synchronous and empties the heap; capacity_limit returns to 64.
// cfg_ready is always high; write it only while the block is idle.
module binary_max_heap #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [31:0] key_in
  input  wire logic [0:0]  s_tuser,  // [0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,  // [31:0] extracted_key, [63:32] top_key,
                                     // [70:64] entry_count, [71] zero
  output logic [1:0]       m_tuser,  // [1:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);
  import bmh_pkg::*;

  cmd_t    cmd;
  stat_t   st;
  result_t res;
  logic    out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  bmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .st       (st),
    .cmd      (cmd)
  );

  bmh_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_limit (cfg_data),
    .op_in     (s_tuser[0]),
    .key_in    (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {1'b0, res.entry_count, res.top_key, res.extracted_key};
      m_tuser <= res.status;
    end
  end

endmodule
`default_nettype wire
